@@ hdl/spq_pkg.sv @@
package spq_pkg;

    localparam int unsigned DefCapacity = 64;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DEQUEUED = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] item_data;
        logic signed [15:0] item_priority;
    } t_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_data;
        logic signed [15:0] out_priority;
        logic [6:0]         occupancy;
    } t_result;

    typedef struct packed {
        logic signed [31:0] data;
        logic signed [15:0] key;
    } t_entry;

    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctl;

endpackage

@@ hdl/spq_cell.sv @@
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  spq_pkg::t_entry    i_new,
    input  spq_pkg::t_entry    i_left,
    input  logic               i_left_after,
    input  spq_pkg::t_entry    i_right,
    input  logic               i_occupied,
    output spq_pkg::t_entry    o_entry,
    output logic               o_after
);
    import spq_pkg::*;

    t_entry r_entry;

    // new item belongs at or before this cell
    assign o_after = !i_occupied || (r_entry.key > i_new.key);
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.enq) begin
            if (i_left_after) begin
                r_entry <= i_left;
            end else if (o_after) begin
                r_entry <= i_new;
            end
        end else if (i_ctl.deq) begin
            r_entry <= i_right;
        end
    end

endmodule

@@ hdl/sorted_priority_queue.sv @@
// Sorted priority queue, a row of CAPACITY cells kept in ascending key order.
// Input channel: drive i_item and pulse i_start; the item is taken at any
// rising edge with i_start high and o_busy low. o_busy stays low, so one
// item may be presented every cycle.
// req_type enqueue inserts (data, priority) after all entries with a key less
// than or equal to its own; dequeue removes the entry with the smallest key.
// Result channel: o_done is high for one cycle, in the cycle after the item
// is taken, with o_result valid in that cycle. Throughput one item per
// cycle: every cell compares its key with the new key and shifts
// left or right in the same cycle, so no item waits on another.
// The receiver cannot stall; a result not taken in its cycle is lost.
// Status: inserted, full rejected, dequeued, empty rejected. out_data and
// out_priority are zero unless an entry was dequeued. occupancy is the count
// after the item, taken modulo 128.
// Reset (i_rst_n low, synchronous) empties the queue and drops o_done; cell
// contents are not cleared and are never read before they are written.
module sorted_priority_queue #(
    parameter int unsigned CAPACITY = spq_pkg::DefCapacity
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  spq_pkg::t_item   i_item,
    output logic             o_busy,
    output logic             o_done,
    output spq_pkg::t_result o_result
);
    import spq_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_done;
    t_result       r_result, n_result;

    t_entry        w_new;
    t_entry        w_entry [CAPACITY];
    logic          w_after [CAPACITY];
    t_cell_ctl     w_ctl;
    logic          w_accept, w_full, w_empty;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_empty  = (r_count == '0);
    assign w_new    = '{data: i_item.item_data, key: i_item.item_priority};

    assign w_ctl.enq = w_accept && (i_item.req_type == REQ_ENQ) && !w_full;
    assign w_ctl.deq = w_accept && (i_item.req_type == REQ_DEQ) && !w_empty;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_new        (w_new),
            .i_left       ((g == 0) ? w_new : w_entry[(g == 0) ? 0 : g - 1]),
            .i_left_after ((g == 0) ? 1'b0 : w_after[(g == 0) ? 0 : g - 1]),
            .i_right      ((g == CAPACITY - 1) ? w_entry[g]
                                               : w_entry[(g == CAPACITY - 1) ? g : g + 1]),
            .i_occupied   (CW'(g) < r_count),
            .o_entry      (w_entry[g]),
            .o_after      (w_after[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_result = '0;
        if (i_item.req_type == REQ_ENQ) begin
            if (w_full) begin
                n_result.status = ST_FULL;
            end else begin
                n_result.status = ST_INSERTED;
                n_count         = r_count + CW'(1);
            end
        end else begin
            if (w_empty) begin
                n_result.status = ST_EMPTY;
            end else begin
                n_result.status       = ST_DEQUEUED;
                n_result.out_data     = w_entry[0].data;
                n_result.out_priority = w_entry[0].key;
                n_count               = r_count - CW'(1);
            end
        end
        n_result.occupancy = 7'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_done)
        else $error("item taken without a result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_start |=> !o_done)
        else $error("result without an item");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_DEQUEUED) |->
            (o_result.out_data == '0 && o_result.out_priority == '0))
        else $error("non-zero payload on a non-dequeue result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count beyond capacity");

    a_full_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_FULL) |-> (r_count == CW'(CAPACITY)))
        else $error("full reported while not full");

endmodule
